@@ sv/sss_pkg.sv @@
`timescale 1ns / 1ps
// Package with shared constants, types and the result record for the sample statistics block.
package sss_pkg;
  localparam int MaxSamples = 1024;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CountW = $clog2(MaxSamples + 1);
  localparam int SumW = 16 + CountW + 1;
  localparam int NumW = SumW + 8;
  localparam int DevW = 25;
  localparam int SqW = 2 * DevW + CountW;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } front_beat_t;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic signed [15:0] min_value;
    logic [15:0]        spread;
    logic signed [23:0] mean_q8;
    logic [23:0]        deviation_q8;
    logic [10:0]        set_count;
    logic               overflowed;
  } result_t;
endpackage

@@ sv/sss_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module sss_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/sss_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue that decouples the input front from the statistics back end.
module sss_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sss_pkg::front_beat_t in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sss_pkg::front_beat_t out_beat
);
  sss_pkg::front_beat_t slot_r [2];
  logic                 rd_ptr_r, wr_ptr_r;
  logic [1:0]           fill_r;
  logic                 push, pop;

  assign in_ready  = (fill_r != 2'd2);
  assign out_valid = (fill_r != 2'd0);
  assign out_beat  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_beat;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd2 |-> !in_ready) else $error("queue overfilled");
  a_valid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (fill_r != 2'd0)) else $error("valid disagrees with fill");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("fill out of range");
endmodule

@@ sv/sss_back.sv @@
`timescale 1ns / 1ps
// Back end: stores and sums samples, then runs mean divide, variance, variance divide and square root passes.
module sss_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sss_pkg::front_beat_t q_beat,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sss_pkg::result_t     res
);
  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StDivM = 3'd1;
  localparam logic [2:0] StVar  = 3'd2;
  localparam logic [2:0] StDivV = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam int DivW = sss_pkg::SqW;
  localparam int DivStepW = $clog2(DivW + 1);

  logic [2:0]                        state_r;
  logic [sss_pkg::CountW-1:0]        count_r;
  logic                              ovf_r;
  logic signed [15:0]                max_r, min_r;
  logic signed [sss_pkg::SumW-1:0]   sum_r;
  logic signed [23:0]                mean_r;
  logic [sss_pkg::SqW-1:0]           sq_r;
  logic [sss_pkg::CountW-1:0]        idx_r;
  logic                              rd_vld_r;
  logic [DivW-1:0]                   quo_r;
  logic [sss_pkg::CountW:0]          rem_r;
  logic [DivStepW-1:0]               step_r;
  logic                              neg_r;
  logic [sss_pkg::SqW-1:0]           sv_r, sr_r, sb_r;
  logic [15:0]                       rdata;
  logic                              we, fits;
  logic [sss_pkg::AddrW-1:0]         raddr;
  logic [sss_pkg::CountW-1:0]        new_count;
  logic signed [sss_pkg::DevW-1:0]   diff;
  logic [sss_pkg::DevW-1:0]          adiff;
  logic [sss_pkg::CountW:0]          rem_sh;
  logic [sss_pkg::SqW:0]             sr_plus;
  logic [sss_pkg::NumW-1:0]          num_abs;
  logic signed [sss_pkg::NumW-1:0]   num;
  logic [DivW-1:0]                   div_src;
  logic [DivW-1:0]                   mean_mag;

  assign fits      = (count_r < sss_pkg::CountW'(sss_pkg::MaxSamples));
  assign q_ready   = (state_r == StLoad);
  assign we        = q_valid && q_ready && fits;
  assign new_count = fits ? count_r + 1'b1 : count_r;
  assign raddr     = idx_r[sss_pkg::AddrW-1:0];
  assign num       = {sum_r, 8'd0};
  assign num_abs   = num[sss_pkg::NumW-1] ? sss_pkg::NumW'(-num) : sss_pkg::NumW'(num);
  assign div_src   = (state_r == StDivM) ? DivW'(num_abs) : DivW'(sq_r);
  assign rem_sh    = {rem_r[sss_pkg::CountW-1:0], div_src[DivW-1-32'(step_r)]};
  assign diff      = (sss_pkg::DevW'(signed'(rdata)) <<< 8) - sss_pkg::DevW'(mean_r);
  assign adiff     = diff[sss_pkg::DevW-1] ? sss_pkg::DevW'(-diff) : sss_pkg::DevW'(diff);
  assign sr_plus   = {1'b0, sr_r} + {1'b0, sb_r};
  assign mean_mag  = quo_r + DivW'(neg_r && (rem_r != '0));

  sss_ram #(.Width(16), .Depth(sss_pkg::MaxSamples)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[sss_pkg::AddrW-1:0]),
    .wdata(q_beat.sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StLoad;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      res_valid <= 1'b0;
      sum_r     <= '0;
    end else begin
      case (state_r)
        StLoad: begin
          if (q_valid) begin
            count_r <= new_count;
            if (!fits) begin
              ovf_r <= 1'b1;
            end else begin
              sum_r <= sum_r + sss_pkg::SumW'(q_beat.sample);
              if (count_r == '0 || q_beat.sample > max_r) max_r <= q_beat.sample;
              if (count_r == '0 || q_beat.sample < min_r) min_r <= q_beat.sample;
            end
            if (q_beat.last_sample) begin
              state_r <= StDivM;
              step_r  <= '0;
              rem_r   <= '0;
              neg_r   <= sum_r + sss_pkg::SumW'(fits ? q_beat.sample : 16'sd0) < 0;
              if (fits) sum_r <= sum_r + sss_pkg::SumW'(q_beat.sample);
            end
          end
        end
        StDivM, StDivV: begin
          if (rem_sh >= {1'b0, count_r}) begin
            rem_r <= rem_sh - {1'b0, count_r};
            quo_r <= {quo_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[DivW-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == DivStepW'(DivW - 1)) begin
            if (state_r == StDivM) begin
              state_r  <= StVar;
              idx_r    <= '0;
              rd_vld_r <= 1'b0;
              sq_r     <= '0;
            end else begin
              state_r <= StSqrt;
              sr_r    <= '0;
              sb_r    <= sss_pkg::SqW'(1) << (sss_pkg::SqW - 2 + (sss_pkg::SqW % 2));
            end
          end
        end
        StVar: begin
          if (state_r == StVar && step_r != '0 && rd_vld_r == 1'b0 && idx_r == '0) begin
            mean_r <= neg_r ? 24'(-mean_mag) : 24'(mean_mag);
          end
          step_r <= '0;
          if (rd_vld_r) begin
            sq_r <= sq_r + sss_pkg::SqW'(adiff * adiff);
          end
          if (idx_r < count_r) begin
            idx_r    <= idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
            if (!rd_vld_r && idx_r != '0) begin
              state_r <= StDivV;
              rem_r   <= '0;
            end
          end
        end
        StSqrt: begin
          if (sb_r != '0) begin
            if ({1'b0, sv_r} >= sr_plus) begin
              sv_r <= sv_r - sr_plus[sss_pkg::SqW-1:0];
              sr_r <= (sr_r >> 1) + sb_r;
            end else begin
              sr_r <= sr_r >> 1;
            end
            sb_r <= sb_r >> 2;
          end else begin
            state_r   <= StOut;
            res_valid <= 1'b1;
            res.max_value    <= max_r;
            res.min_value    <= min_r;
            res.spread       <= 16'(max_r - min_r);
            res.mean_q8      <= mean_r;
            res.deviation_q8 <= sr_r[23:0];
            res.set_count    <= 11'(count_r);
            res.overflowed   <= ovf_r;
          end
        end
        StOut: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state_r   <= StLoad;
            count_r   <= '0;
            ovf_r     <= 1'b0;
            sum_r     <= '0;
          end
        end
        default: state_r <= StLoad;
      endcase
    end
    if (state_r == StDivV && step_r == DivStepW'(DivW - 1)) begin
      sv_r <= sss_pkg::SqW'({quo_r[DivW-2:0], rem_sh >= {1'b0, count_r}});
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> state_r == StOut) else $error("result outside output state");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != StLoad |-> !q_ready) else $error("input taken while busy");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sss_pkg::CountW'(sss_pkg::MaxSamples)) else $error("count over capacity");
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> count_r != '0) else $error("empty set reported");
endmodule

@@ sv/sample_set_statistics.sv @@
`timescale 1ns / 1ps
// Top level of the sample set statistics block.
// Samples load only while the back end is in its load state; after the last sample
// of a set it runs two long divisions, a variance pass over the sample RAM and a
// square root, then holds the result until out_tready, taking no samples meanwhile.
// Sustained rate is one sample per cycle while loading, plus the per-set tail above.
// Synchronous active-low reset empties the set and the queue; the RAM is not cleared.
module sample_set_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // sample
  input  logic        in_tlast,  // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // max_value, min_value, spread, mean_q8, deviation_q8, set_count, overflowed
  output logic [111:0] out_tdata
);
  sss_pkg::front_beat_t in_beat, q_beat;
  sss_pkg::result_t     res;
  logic                 q_valid, q_ready;

  assign in_beat.sample      = signed'(in_tdata);
  assign in_beat.last_sample = in_tlast;

  sss_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_beat(in_beat),
    .out_valid(q_valid), .out_ready(q_ready), .out_beat(q_beat)
  );

  sss_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {4'd0, res.overflowed, res.set_count, res.deviation_q8,
                      res.mean_q8, res.spread, res.min_value, res.max_value};
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sample_set_statistics with a built-in predictor and random stalls.
module tb;
  typedef struct {
    logic signed [15:0] sample;
    logic               last_sample;
  } sample_beat_t;

  typedef struct {
    logic signed [15:0] max_value;
    logic signed [15:0] min_value;
    logic [15:0]        spread;
    logic signed [23:0] mean_q8;
    logic [23:0]        deviation_q8;
    logic [10:0]        set_count;
    logic               overflowed;
  } set_stats_t;

  localparam int WatchdogLimit = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;

  sample_beat_t pending_beats[$];
  set_stats_t   expected_stats[$];
  logic signed [15:0] set_samples[$];
  logic         set_overflow = 1'b0;
  int           send_idle_pct = 29;
  int           recv_idle_pct = 72;
  bit           hold_sender = 1'b0;
  bit           done_sending = 1'b0;
  int           error_count = 0;
  int           quiet_cycles = 0;

  sample_set_statistics DUT (.*);

  always #4 clk = ~clk;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic set_stats_t compute_set_stats(input logic signed [15:0] s[$],
                                                   input logic ovf);
    set_stats_t st;
    longint sum;
    longint num;
    longint mean;
    longint d;
    longint n;
    logic [63:0] sq;
    int mx;
    int mn;
    sum = 0;
    sq = 0;
    n = s.size();
    mx = s[0];
    mn = s[0];
    foreach (s[i]) begin
      if (s[i] > mx) mx = s[i];
      if (s[i] < mn) mn = s[i];
      sum += s[i];
    end
    num = sum * 256;
    mean = num / n;
    if (num % n != 0 && num < 0) mean--;
    foreach (s[i]) begin
      d = longint'(s[i]) * 256 - mean;
      if (d < 0) d = -d;
      sq += d * d;
    end
    st.max_value = 16'(mx);
    st.min_value = 16'(mn);
    st.spread = 16'(mx - mn);
    st.mean_q8 = mean[23:0];
    st.deviation_q8 = 24'(isqrt64(sq / 64'(n)));
    st.set_count = 11'(n);
    st.overflowed = ovf;
    return st;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (set_samples.size() < sss_pkg::MaxSamples) set_samples.push_back(in_tdata);
      else set_overflow = 1'b1;
      if (in_tlast) begin
        expected_stats.push_back(compute_set_stats(set_samples, set_overflow));
        set_samples.delete();
        set_overflow = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_beats.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_beats[0].sample;
        in_tlast <= pending_beats[0].last_sample;
        void'(pending_beats.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    set_stats_t got;
    set_stats_t want;
    got.max_value = out_tdata[15:0];
    got.min_value = out_tdata[31:16];
    got.spread = out_tdata[47:32];
    got.mean_q8 = out_tdata[71:48];
    got.deviation_q8 = out_tdata[95:72];
    got.set_count = out_tdata[106:96];
    got.overflowed = out_tdata[107];
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stats.size() == 0) begin
        $display("%t: unexpected result %h", $realtime, out_tdata);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        if (got.max_value !== want.max_value || got.min_value !== want.min_value ||
            got.spread !== want.spread || got.mean_q8 !== want.mean_q8 ||
            got.deviation_q8 !== want.deviation_q8 || got.set_count !== want.set_count ||
            got.overflowed !== want.overflowed) begin
          $display("%t: expected max %0d min %0d spread %0d mean %0d dev %0d n %0d ovf %0b",
                   $realtime, want.max_value, want.min_value, want.spread, want.mean_q8,
                   want.deviation_q8, want.set_count, want.overflowed);
          $display("%t: actual   max %0d min %0d spread %0d mean %0d dev %0d n %0d ovf %0b",
                   $realtime, got.max_value, got.min_value, got.spread, got.mean_q8,
                   got.deviation_q8, got.set_count, got.overflowed);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_set(input int len, input int style);
    sample_beat_t b;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b.sample = 16'($urandom);
        1: b.sample = 16'($urandom_range(200) - 100);
        2: b.sample = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        default: b.sample = 16'(16'sh1234 + $urandom_range(3));
      endcase
      b.last_sample = (i == len - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic add_beat(input logic signed [15:0] s, input logic l);
    sample_beat_t b;
    b.sample = s;
    b.last_sample = l;
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_tvalid || expected_stats.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int beats);
    int queued;
    int len;
    queued = 0;
    while (queued < beats) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1) + 1 : $urandom_range(12) + 1;
      add_set(len, $urandom_range(3));
      queued += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    add_beat(16'sh7fff, 1'b1);
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh7fff, 1'b0);
    add_beat(16'sh8000, 1'b1);
    add_beat(-16'sd1, 1'b0);
    add_beat(16'sd0, 1'b0);
    add_beat(16'sd0, 1'b1);
    add_beat(16'sd5, 1'b0);
    add_beat(16'sd5, 1'b1);
    add_beat(-16'sd3, 1'b0);
    add_beat(16'sd0, 1'b0);
    add_beat(16'sd2, 1'b1);
    add_set(4, 2);
    drain();
    hold_sender = 1'b1;
    add_set(200, 0);
    repeat (3) @(posedge clk);
    hold_sender = 1'b0;
    add_set(sss_pkg::MaxSamples + 1, 1);
    random_phase(100);
    drain();
    send_idle_pct = 72;
    recv_idle_pct = 29;
    random_phase(200);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    drain();
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
